### hw/rtl/gob_pkg.sv
// gob_pkg: payload types, pipeline word and fixed constants of the gradient
// orientation binning block. No dependencies; imported by every gob module.
`default_nettype none

package gob_pkg;

    // one input transfer: the four gray neighbors of a pixel
    typedef struct packed {
        logic [7:0] pixel_left;
        logic [7:0] pixel_right;
        logic [7:0] pixel_above;
        logic [7:0] pixel_below;
    } t_pix_in;

    // one result transfer
    typedef struct packed {
        logic        has_gradient;
        logic [2:0]  bin_lower;
        logic [2:0]  bin_upper;
        logic [15:0] weight_lower;
        logic [15:0] weight_upper;
    } t_result;

    // widths of the pipeline word
    localparam int SUMSQ_W = 17;   // dx*dx + dy*dy
    localparam int ROOT_W  = 25;   // floor(sqrt(sumsq * 2^32))
    localparam int REM_W   = 28;   // square root remainder
    localparam int VEC_W   = 36;   // cordic x and y, scaled by 2^24
    localparam int PHASE_W = 32;   // turn fraction, 2^32 = full turn
    localparam int MAG_W   = 16;

    // number of pipelined steps
    localparam int CORDIC_STEPS = 24;
    localparam int SQRT_STEPS   = ROOT_W;
    // low result bit pairs of the root come from the 2^32 scale (zero bits)
    localparam int SQRT_ZERO_PAIRS = 16;
    localparam int CORDIC_SCALE    = 24;

    // axis direction codes, phase = code * quarter turn
    localparam logic [1:0] QUAD_EAST  = 2'd0;
    localparam logic [1:0] QUAD_NORTH = 2'd1;
    localparam logic [1:0] QUAD_WEST  = 2'd2;
    localparam logic [1:0] QUAD_SOUTH = 2'd3;

    localparam logic [PHASE_W-1:0] HALF_TURN = 32'h8000_0000;

    // magnitude = (root + 255) / 510 = ((root + 255) >> 1) / 255
    localparam logic [ROOT_W-1:0] ROUND_HALF = 25'd255;
    localparam logic [ROOT_W-1:0] RECIP_255  = 25'd16843010;   // ceil(2^32 / 255)
    localparam int                RECIP_SHIFT = 32;

    // bin numbers inside the pipe (bin count is at most 16)
    localparam int BIN_W = 5;

    typedef struct packed {
        logic       zero;   // dx and dy both zero
        logic       axis;   // dx or dy zero: exact phase from quad
        logic [1:0] quad;
    } t_flags;

    // word carried through the square root and cordic steps
    typedef struct packed {
        t_flags                     flags;
        logic [SUMSQ_W-1:0]         sumsq;
        logic [ROOT_W-1:0]          root;
        logic [REM_W-1:0]           rem;
        logic signed [VEC_W-1:0]    x;
        logic signed [VEC_W-1:0]    y;
        logic [PHASE_W-1:0]         z;
    } t_step;

    // arctangent of 2^-i in turn units
    function automatic logic [PHASE_W-1:0] atan_turn(input int idx);
        logic [PHASE_W-1:0] v;
        unique case (idx)
            0:  v = 32'd536870912;
            1:  v = 32'd316933406;
            2:  v = 32'd167458907;
            3:  v = 32'd85004756;
            4:  v = 32'd42667331;
            5:  v = 32'd21354465;
            6:  v = 32'd10679838;
            7:  v = 32'd5340245;
            8:  v = 32'd2670163;
            9:  v = 32'd1335087;
            10: v = 32'd667544;
            11: v = 32'd333772;
            12: v = 32'd166886;
            13: v = 32'd83443;
            14: v = 32'd41722;
            15: v = 32'd20861;
            16: v = 32'd10430;
            17: v = 32'd5215;
            18: v = 32'd2608;
            19: v = 32'd1304;
            20: v = 32'd652;
            21: v = 32'd326;
            22: v = 32'd163;
            23: v = 32'd81;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/gob_front.sv
// gob_front: first pipeline stage, central differences, sum of squares and
// cordic start vector. Depends on gob_pkg.
`default_nettype none

module gob_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  gob_pkg::t_pix_in i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output gob_pkg::t_step   o_data
);
    import gob_pkg::*;

    logic signed [8:0]       w_dx;
    logic signed [8:0]       w_dy;
    logic signed [17:0]      w_dx2;
    logic signed [17:0]      w_dy2;
    logic signed [VEC_W-1:0] w_x0;
    logic signed [VEC_W-1:0] w_y0;
    t_step                   n_data;
    logic                    r_valid;
    t_step                   r_data;

    // central differences
    assign w_dx  = $signed({1'b0, i_data.pixel_right}) - $signed({1'b0, i_data.pixel_left});
    assign w_dy  = $signed({1'b0, i_data.pixel_below}) - $signed({1'b0, i_data.pixel_above});
    assign w_dx2 = w_dx * w_dx;
    assign w_dy2 = w_dy * w_dy;
    assign w_x0  = VEC_W'(w_dx) <<< CORDIC_SCALE;
    assign w_y0  = VEC_W'(w_dy) <<< CORDIC_SCALE;

    // next pipeline word
    always_comb begin
        n_data        = '0;
        n_data.sumsq  = SUMSQ_W'($unsigned(w_dx2)) + SUMSQ_W'($unsigned(w_dy2));
        n_data.flags.zero = (w_dx == 9'sd0) && (w_dy == 9'sd0);
        n_data.flags.axis = (w_dx == 9'sd0) || (w_dy == 9'sd0);
        priority if (w_dy == 9'sd0) begin
            n_data.flags.quad = (w_dx > 9'sd0) ? QUAD_EAST : QUAD_WEST;
        end else begin
            n_data.flags.quad = (w_dy > 9'sd0) ? QUAD_NORTH : QUAD_SOUTH;
        end
        // left half plane: turn by half a turn first
        if (w_dx < 9'sd0) begin
            n_data.x = -w_x0;
            n_data.y = -w_y0;
            n_data.z = HALF_TURN;
        end else begin
            n_data.x = w_x0;
            n_data.y = w_y0;
            n_data.z = '0;
        end
    end

    assign o_ready = !r_valid || i_ready;

    // stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

### hw/rtl/gob_step.sv
// gob_step: one pipeline stage doing one square root digit and, if STEP <
// CORDIC_STEPS, one cordic vectoring step on the word. Depends on gob_pkg.
`default_nettype none

module gob_step #(
    parameter int STEP = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  gob_pkg::t_step i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output gob_pkg::t_step o_data
);
    import gob_pkg::*;

    localparam int SQRT_BIT = SQRT_STEPS - 1 - STEP;

    logic [1:0]              w_pair;
    logic [REM_W-1:0]        w_rem_sh;
    logic [REM_W-1:0]        w_trial;
    logic signed [VEC_W-1:0] w_x;
    logic signed [VEC_W-1:0] w_y;
    logic [PHASE_W-1:0]      w_z;
    t_step                   n_data;
    logic                    r_valid;
    t_step                   r_data;

    // radicand bit pair for this digit, low pairs are the zero scale bits
    generate
        if (SQRT_BIT >= SQRT_ZERO_PAIRS) begin : g_pair
            localparam int PL = 2 * (SQRT_BIT - SQRT_ZERO_PAIRS);
            logic [SUMSQ_W:0] w_s_ext;
            assign w_s_ext = {1'b0, i_data.sumsq};
            assign w_pair  = w_s_ext[PL+1:PL];
        end else begin : g_nopair
            assign w_pair = 2'b00;
        end
    endgenerate

    // restoring square root digit
    assign w_rem_sh = {i_data.rem[REM_W-3:0], w_pair};
    assign w_trial  = {1'b0, i_data.root, 2'b01};

    // cordic vectoring step, shifts floor toward minus infinity
    generate
        if (STEP < CORDIC_STEPS) begin : g_cordic
            localparam logic [PHASE_W-1:0] ATAN = atan_turn(STEP);
            logic signed [VEC_W-1:0] w_xs;
            logic signed [VEC_W-1:0] w_ys;
            assign w_xs = i_data.x >>> STEP;
            assign w_ys = i_data.y >>> STEP;
            always_comb begin
                if (!i_data.y[VEC_W-1]) begin
                    w_x = i_data.x + w_ys;
                    w_y = i_data.y - w_xs;
                    w_z = i_data.z + ATAN;
                end else begin
                    w_x = i_data.x - w_ys;
                    w_y = i_data.y + w_xs;
                    w_z = i_data.z - ATAN;
                end
            end
        end else begin : g_pass
            assign w_x = i_data.x;
            assign w_y = i_data.y;
            assign w_z = i_data.z;
        end
    endgenerate

    // next pipeline word
    always_comb begin
        n_data   = i_data;
        n_data.x = w_x;
        n_data.y = w_y;
        n_data.z = w_z;
        if (w_rem_sh >= w_trial) begin
            n_data.rem  = w_rem_sh - w_trial;
            n_data.root = {i_data.root[ROOT_W-2:0], 1'b1};
        end else begin
            n_data.rem  = w_rem_sh;
            n_data.root = {i_data.root[ROOT_W-2:0], 1'b0};
        end
    end

    assign o_ready = !r_valid || i_ready;

    // stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

### hw/rtl/gob_back.sv
// gob_back: last four pipeline stages, magnitude scaling, bin position and
// weight split; the last stage is the output register. Depends on gob_pkg.
`default_nettype none

module gob_back #(
    parameter int BINS = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  gob_pkg::t_step   i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output gob_pkg::t_result o_data
);
    import gob_pkg::*;

    localparam logic [BIN_W-1:0] BINS_B = BIN_W'(BINS);
    localparam int               PROD_W = 2 * ROOT_W;

    typedef struct packed {
        logic              zero;
        logic [PROD_W-1:0] prod;
        logic [BIN_W-1:0]  lo;
        logic [15:0]       frac;
    } t_s1;

    typedef struct packed {
        logic             zero;
        logic [MAG_W-1:0] mag;
        logic [BIN_W-1:0] lo;
        logic [BIN_W-1:0] hi;
        logic [15:0]      frac;
    } t_s2;

    typedef struct packed {
        logic             zero;
        logic [MAG_W-1:0] mag;
        logic [MAG_W-1:0] wu;
        logic [BIN_W-1:0] lo;
        logic [BIN_W-1:0] hi;
    } t_s3;

    logic                r_v1, r_v2, r_v3, r_v4;
    logic                w_e1, w_e2, w_e3, w_e4;
    t_s1                 r_d1, n_d1;
    t_s2                 r_d2, n_d2;
    t_s3                 r_d3, n_d3;
    t_result             r_d4, n_d4;
    logic [ROOT_W:0]     w_rr;
    logic [PHASE_W-1:0]  w_zp;
    logic [PHASE_W-1:0]  w_t;
    logic [PHASE_W+BIN_W-1:0] w_pos;
    logic [BIN_W-1:0]    w_lo1;
    logic [31:0]         w_wprod;

    // stage enables, a stage moves when it is empty or its successor moves
    assign w_e4    = !r_v4 || i_ready;
    assign w_e3    = !r_v3 || w_e4;
    assign w_e2    = !r_v2 || w_e3;
    assign w_e1    = !r_v1 || w_e2;
    assign o_ready = w_e1;

    // stage 1: divide by 510 via reciprocal, phase to bin position
    assign w_rr  = (ROOT_W+1)'(i_data.root) + (ROOT_W+1)'(ROUND_HALF);
    assign w_zp  = i_data.flags.axis ? {i_data.flags.quad, {(PHASE_W-2){1'b0}}} : i_data.z;
    assign w_t   = w_zp + HALF_TURN;
    assign w_pos = {{BIN_W{1'b0}}, w_t} * {{PHASE_W{1'b0}}, BINS_B};

    always_comb begin
        n_d1.zero = i_data.flags.zero;
        n_d1.prod = w_rr[ROOT_W:1] * RECIP_255;
        n_d1.lo   = w_pos[PHASE_W+BIN_W-1:PHASE_W];
        n_d1.frac = w_pos[PHASE_W-1:PHASE_W-16];
    end

    // stage 2: magnitude and upper bin
    assign w_lo1 = r_d1.lo + BIN_W'(1);

    always_comb begin
        n_d2.zero = r_d1.zero;
        n_d2.mag  = r_d1.prod[RECIP_SHIFT+MAG_W-1:RECIP_SHIFT];
        n_d2.lo   = r_d1.lo;
        n_d2.hi   = (w_lo1 == BINS_B) ? '0 : w_lo1;
        n_d2.frac = r_d1.frac;
    end

    // stage 3: upper weight
    assign w_wprod = r_d2.mag * r_d2.frac;

    always_comb begin
        n_d3.zero = r_d2.zero;
        n_d3.mag  = r_d2.mag;
        n_d3.wu   = w_wprod[31:16];
        n_d3.lo   = r_d2.lo;
        n_d3.hi   = r_d2.hi;
    end

    // stage 4: lower weight and result word, zero gradient clears all
    always_comb begin
        if (r_d3.zero) begin
            n_d4 = '0;
        end else begin
            n_d4.has_gradient = 1'b1;
            n_d4.bin_lower    = r_d3.lo[2:0];
            n_d4.bin_upper    = r_d3.hi[2:0];
            n_d4.weight_lower = r_d3.mag - r_d3.wu;
            n_d4.weight_upper = r_d3.wu;
        end
    end

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_e1) r_v1 <= i_valid;
            if (w_e2) r_v2 <= r_v1;
            if (w_e3) r_v3 <= r_v2;
            if (w_e4) r_v4 <= r_v3;
        end
    end

    // stage payloads
    always_ff @(posedge i_clk) begin
        if (w_e1 && i_valid) r_d1 <= n_d1;
        if (w_e2 && r_v1)    r_d2 <= n_d2;
        if (w_e3 && r_v2)    r_d3 <= n_d3;
        if (w_e4 && r_v3)    r_d4 <= n_d4;
    end

    assign o_valid = r_v4;
    assign o_data  = r_d4;

    // no gradient means no weight and no bins
    a_zero_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && !r_d4.has_gradient) |->
            (r_d4.weight_lower == '0 && r_d4.weight_upper == '0 &&
             r_d4.bin_lower == '0 && r_d4.bin_upper == '0))
        else $error("zero gradient result carries nonzero fields");

    // the two weights add up to the magnitude, which stays below 46342
    a_weight_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v4 |-> ((17'(r_d4.weight_lower) + 17'(r_d4.weight_upper)) <= 17'd46341))
        else $error("weight split exceeds magnitude range");

    // a held result is not replaced while the sink stalls
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && !i_ready) |=> (r_v4 && $stable(r_d4)))
        else $error("stalled result changed");

    // a full stage ahead of a stalled output blocks its predecessor
    a_chain_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && r_v3 && r_v2 && r_v1 && !i_ready) |-> !o_ready)
        else $error("pipeline accepts into a full stalled chain");

endmodule

`default_nettype wire

### hw/rtl/gradient_orientation_binning.sv
// gradient_orientation_binning: top level, front stage, square root and
// cordic step chain, back end. Depends on gob_pkg, gob_front, gob_step, gob_back.
`default_nettype none

// Takes the four gray neighbors of a pixel and returns the gradient magnitude
// split between the two nearest orientation bins (unsigned Q16.0 weights), plus
// a flag that is low for a flat neighborhood. One transfer can enter every
// clock cycle until a stalled output fills the chain, and each passes one
// stage of differences, 25 stages that each resolve one square root digit (the
// first 24 also one cordic rotation), four stages for the divide by 510, the bin
// position and the weight multiply. Every stage holds its word independently,
// so while the output waits empty stages keep filling and o_ready stays high
// until the whole chain is full. BINS sets the number of orientation bins
// (2 to 16); bin fields are 3 bits and report the bin number modulo 8.
module gradient_orientation_binning #(
    parameter int BINS = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  gob_pkg::t_pix_in i_pixels,
    output logic             o_valid,
    input  logic             i_ready,
    output gob_pkg::t_result o_result
);
    import gob_pkg::*;

    logic  w_valid [SQRT_STEPS+1];
    logic  w_ready [SQRT_STEPS+1];
    t_step w_data  [SQRT_STEPS+1];

    // differences and start vector
    gob_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_pixels),
        .o_valid (w_valid[0]),
        .i_ready (w_ready[0]),
        .o_data  (w_data[0])
    );

    // square root digit and cordic rotation chain
    generate
        for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
            gob_step #(
                .STEP (k)
            ) u_step (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_valid (w_valid[k]),
                .o_ready (w_ready[k]),
                .i_data  (w_data[k]),
                .o_valid (w_valid[k+1]),
                .i_ready (w_ready[k+1]),
                .o_data  (w_data[k+1])
            );
        end
    endgenerate

    // magnitude scaling, binning, weights and output register
    gob_back #(
        .BINS (BINS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid[SQRT_STEPS]),
        .o_ready (w_ready[SQRT_STEPS]),
        .i_data  (w_data[SQRT_STEPS]),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_result)
    );

endmodule

`default_nettype wire

### tb/sv/tb.sv
`timescale 1ns / 1ps
// tb: self-checking testbench for gradient_orientation_binning, predicts each
// result in fixed point and compares it with the block's output stream.
// Depends on gob_pkg and the gradient_orientation_binning rtl.

module tb;

    import gob_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 9;
    localparam int NUM_BINS     = 8;
    localparam int RANDOM_ITEMS = 830;
    localparam int DRAIN_CYCLES = 40;     // pipeline is 30 deep
    localparam int STALL_LIMIT  = 4000;

    localparam logic [31:0] TURN_HALF    = 32'h8000_0000;
    localparam logic [31:0] TURN_QUARTER = 32'h4000_0000;
    localparam logic [31:0] TURN_3QUARTER = 32'hC000_0000;

    // arctangent of 2^-i as a fraction of a full turn
    localparam logic [31:0] ATAN_TURNS [24] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PERIODIC} t_rx_mode;

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_valid = 1'b0;
    logic     o_ready;
    t_pix_in  i_pixels = '0;
    logic     o_valid;
    logic     i_ready = 1'b0;
    t_result  o_result;

    t_result  pending_results[$];
    int       failures = 0;
    int       items_sent = 0;
    int       results_checked = 0;
    int       flat_results = 0;
    logic [7:0] lower_bins_seen = '0;
    int       idle_cycles = 0;
    int       burst_left = 0;

    t_rx_mode rx_mode = RX_ALWAYS;
    int       rx_left = 0;
    int       rx_count = 0;
    int       rx_period = 2;
    int       rx_stall_len = 1;

    gradient_orientation_binning #(
        .BINS (NUM_BINS)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_pixels (i_pixels),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (o_result)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // expected result of one neighborhood: rounded magnitude, cordic phase,
    // soft split between two neighboring bins
    function automatic t_result predict_binning(t_pix_in px);
        longint dx, dy, x, y, xs, ys;
        longint unsigned sq, bitv, root, mag, pos, frac, wu;
        logic [31:0] z;
        int lo, hi, i;
        t_result r;
        r = '0;
        dx = longint'(px.pixel_right) - longint'(px.pixel_left);
        dy = longint'(px.pixel_below) - longint'(px.pixel_above);
        if (dx == 0 && dy == 0) begin
            return r;
        end

        // integer square root of the sum of squares scaled by 2^32
        sq = longint'(dx * dx + dy * dy) << 32;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > sq) bitv >>= 2;
        while (bitv != 0) begin
            if (sq >= root + bitv) begin
                sq -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        mag = (root + 255) / 510;
        if (mag > 64'hFFFF) mag = 64'hFFFF;

        // phase as a turn fraction; axis directions are exact
        if (dy == 0) begin
            z = (dx > 0) ? 32'h0 : TURN_HALF;
        end else if (dx == 0) begin
            z = (dy > 0) ? TURN_QUARTER : TURN_3QUARTER;
        end else begin
            x = dx * 16777216;
            y = dy * 16777216;
            z = '0;
            if (dx < 0) begin
                x = -x;
                y = -y;
                z = TURN_HALF;
            end
            for (i = 0; i < 24; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (y >= 0) begin
                    x = x + ys;
                    y = y - xs;
                    z = z + ATAN_TURNS[i];
                end else begin
                    x = x - ys;
                    y = y + xs;
                    z = z - ATAN_TURNS[i];
                end
            end
        end

        // bin position, fraction and weight split
        z = z + TURN_HALF;
        pos = 64'(z) * 64'(NUM_BINS);
        lo = int'(pos >> 32);
        frac = (pos >> 16) & 64'hFFFF;
        hi = lo + 1;
        if (hi >= NUM_BINS) hi = 0;
        wu = (mag * frac) >> 16;

        r.has_gradient = 1'b1;
        r.bin_lower    = lo[2:0];
        r.bin_upper    = hi[2:0];
        r.weight_lower = 16'(mag - wu);
        r.weight_upper = 16'(wu);
        return r;
    endfunction

    task automatic check_field(input string field, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, actual %0d", field, want, got);
            failures++;
        end
    endtask

    // monitor: check each output transfer, queue a prediction per input transfer
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (pending_results.size() == 0) begin
                    $error("result transfer with no expected result pending");
                    failures++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("has_gradient", 16'(want.has_gradient),
                                16'(o_result.has_gradient));
                    check_field("bin_lower", 16'(want.bin_lower),
                                16'(o_result.bin_lower));
                    check_field("bin_upper", 16'(want.bin_upper),
                                16'(o_result.bin_upper));
                    check_field("weight_lower", want.weight_lower, o_result.weight_lower);
                    check_field("weight_upper", want.weight_upper, o_result.weight_upper);
                    results_checked++;
                    if (!want.has_gradient) flat_results++;
                    else lower_bins_seen[want.bin_lower] = 1'b1;
                end
            end
            if (i_valid && o_ready) begin
                pending_results.push_back(predict_binning(i_pixels));
            end
        end
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
    end

    // receiver backpressure: always ready, coin flip, or periodic stall stretches
    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 2));
            rx_left = $urandom_range(40, 160);
            rx_period = $urandom_range(2, 40);
            rx_stall_len = $urandom_range(1, rx_period - 1);
            rx_count = 0;
        end
        rx_left--;
        rx_count = (rx_count + 1) % rx_period;
        case (rx_mode)
            RX_ALWAYS: i_ready <= 1'b1;
            RX_RANDOM: i_ready <= ($urandom_range(0, 1) == 1);
            default:   i_ready <= (rx_count >= rx_stall_len);
        endcase
    end

    // one input transfer, then an occasional gap between bursts
    task automatic send_pixels(input logic [7:0] left, input logic [7:0] right,
                               input logic [7:0] above, input logic [7:0] below);
        int gap;
        @(negedge i_clk);
        i_valid  <= 1'b1;
        i_pixels <= t_pix_in'{pixel_left: left, pixel_right: right,
                              pixel_above: above, pixel_below: below};
        do @(posedge i_clk); while (!o_ready);
        items_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, 15);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(0, 24);
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    function automatic logic [7:0] near_value(input logic [7:0] base, input int spread);
        int v;
        v = int'(base) + $urandom_range(0, 2 * spread) - spread;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return v[7:0];
    endfunction

    // zero gradient: flag low and all fields zero
    task automatic test_flat_patches();
        send_pixels(8'd0, 8'd0, 8'd0, 8'd0);
        send_pixels(8'd255, 8'd255, 8'd255, 8'd255);
        send_pixels(8'd7, 8'd7, 8'd200, 8'd200);
        send_pixels(8'd128, 8'd128, 8'd33, 8'd33);
    endtask

    // exact axis phases, including the position that wraps back to bin 0
    task automatic test_axis_directions();
        send_pixels(8'd0, 8'd255, 8'd9, 8'd9);
        send_pixels(8'd255, 8'd0, 8'd9, 8'd9);
        send_pixels(8'd10, 8'd11, 8'd50, 8'd50);
        send_pixels(8'd11, 8'd10, 8'd50, 8'd50);
        send_pixels(8'd40, 8'd40, 8'd0, 8'd255);
        send_pixels(8'd40, 8'd40, 8'd255, 8'd0);
        send_pixels(8'd3, 8'd3, 8'd100, 8'd101);
        send_pixels(8'd3, 8'd3, 8'd101, 8'd100);
    endtask

    // diagonals at full and unit size, upper bin wrapping after the last bin
    task automatic test_extreme_diagonals();
        send_pixels(8'd0, 8'd255, 8'd0, 8'd255);
        send_pixels(8'd255, 8'd0, 8'd0, 8'd255);
        send_pixels(8'd0, 8'd255, 8'd255, 8'd0);
        send_pixels(8'd255, 8'd0, 8'd255, 8'd0);
        send_pixels(8'd0, 8'd1, 8'd0, 8'd1);
        send_pixels(8'd1, 8'd0, 8'd1, 8'd0);
        send_pixels(8'd0, 8'd1, 8'd1, 8'd0);
        send_pixels(8'd1, 8'd0, 8'd0, 8'd1);
        send_pixels(8'd255, 8'd0, 8'd0, 8'd1);
        send_pixels(8'd255, 8'd0, 8'd1, 8'd0);
    endtask

    // mix of arbitrary, small, axis, flat and saturated neighborhoods
    task automatic test_random_gradients(input int count);
        logic [7:0] p [4];
        logic [7:0] base;
        int kind, spread, n, k;
        for (n = 0; n < count; n++) begin
            kind = $urandom_range(0, 99);
            for (k = 0; k < 4; k++) p[k] = 8'($urandom_range(0, 255));
            if (kind < 55) begin
                // fully random neighborhood
            end else if (kind < 75) begin
                base = 8'($urandom_range(0, 255));
                spread = $urandom_range(1, 6);
                for (k = 0; k < 4; k++) p[k] = near_value(base, spread);
            end else if (kind < 85) begin
                if ($urandom_range(0, 1) == 1) p[3] = p[2];
                else p[1] = p[0];
            end else if (kind < 92) begin
                p[1] = p[0];
                p[3] = p[2];
            end else begin
                for (k = 0; k < 4; k++) p[k] = ($urandom_range(0, 1) == 1) ? 8'd255 : 8'd0;
            end
            send_pixels(p[0], p[1], p[2], p[3]);
        end
    endtask

    // watchdog on cycles without any transfer
    initial begin
        while (idle_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
        $display("simulation failed");
        $finish;
    end

    initial begin
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_flat_patches();
        test_axis_directions();
        test_extreme_diagonals();
        test_random_gradients(RANDOM_ITEMS);

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d neighborhoods, compared %0d results", items_sent,
                 results_checked);
        $display("flat neighborhoods %0d, lower bins reached %b", flat_results,
                 lower_bins_seen);
        if (failures == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
